[sv/lcsi_pkg.sv]
// Shared types and constants for the lattice coordinate to site index unit.
package lcsi_pkg;

	// Width of the site index word.
	localparam int IDX_W = 20;

	// Configuration port geometry.
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

	// Reset value of every extent register.
	localparam logic [CFG_W-1:0] CELLS_RESET = 7'd4;

	// Dividend bits retired per stage of the remainder pipeline.
	localparam int MOD_STEP = 4;

	// Low three bits of each sublattice offset, per axis (x, y, z).
	localparam int NUM_SUB = 4;
	localparam logic [2:0] SUB_OFF [NUM_SUB][3] = '{
		'{3'd0, 3'd0, 3'd0},
		'{3'd0, 3'd4, 3'd4},
		'{3'd4, 3'd0, 3'd4},
		'{3'd4, 3'd4, 3'd0}
	};

	// Side information that travels alongside the remainder lanes.
	typedef struct packed {
		logic       valid;
		logic       match;
		logic [1:0] sl;
	} side_t;

endpackage

[sv/lcsi_wrap_mod.sv]
// Pipelined non-negative remainder of a signed value by a small extent.
module lcsi_wrap_mod #(
	parameter int DW     = 16,
	parameter int NB     = 7,
	parameter int STEP   = 4,
	parameter int STAGES = 4
) (
	input  logic                 clk,
	input  logic signed [DW-1:0] value,
	input  logic        [NB-1:0] n,
	output logic        [NB-1:0] rem
);
	import lcsi_pkg::*;

	localparam int PW = STAGES * STEP;

	logic [PW-1:0] dvd_s [0:STAGES];
	logic [NB-1:0] rem_s [0:STAGES];
	logic          neg_s [0:STAGES];
	logic [NB-1:0] rem_q;

	// Entry stage: split the value into sign and magnitude.
	always_ff @(posedge clk) begin
		neg_s[0] <= value[DW-1];
		dvd_s[0] <= value[DW-1] ? PW'(~value + DW'(1)) : PW'(value);
		rem_s[0] <= '0;
	end

	// Restoring remainder, STEP dividend bits per stage, MSB first.
	for (genvar k = 1; k <= STAGES; k++) begin : g_step
		logic [PW-1:0] d_w;
		logic [NB-1:0] r_w;
		logic [NB:0]   t_w;

		always_comb begin
			d_w = dvd_s[k-1];
			r_w = rem_s[k-1];
			t_w = '0;
			for (int j = 0; j < STEP; j++) begin
				t_w = {r_w, d_w[PW-1]};
				d_w = {d_w[PW-2:0], 1'b0};
				if (t_w >= {1'b0, n}) begin
					t_w = t_w - {1'b0, n};
				end
				r_w = t_w[NB-1:0];
			end
		end

		always_ff @(posedge clk) begin
			dvd_s[k] <= d_w;
			rem_s[k] <= r_w;
			neg_s[k] <= neg_s[k-1];
		end
	end

	// A negative value with a nonzero remainder wraps to the extent minus it.
	always_ff @(posedge clk) begin
		if (neg_s[STAGES] && (rem_s[STAGES] != '0)) begin
			rem_q <= n - rem_s[STAGES];
		end else begin
			rem_q <= rem_s[STAGES];
		end
	end

	assign rem = rem_q;

endmodule

[sv/lattice_coord_to_site_index_unit.sv]
// Top level of the pyrochlore lattice coordinate to site index unit.
//
// Maps an integer position to its linear site index. A word is taken at every rising edge
// where start is high; busy never rises, so the unit takes one word per cycle without pause.
// Each word yields one result, shown for one cycle under done, after it passes stage 1,
// stage 2, the three remainder lanes (four dividend bits per stage), stage 3, stage 4
// and the output stage. Results cannot be held off.
// Extent registers may be rewritten only while no word is in flight.
module lattice_coord_to_site_index_unit #(
	parameter int COORD_BITS = 16,
	parameter int MAX_CELLS  = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [COORD_BITS-1:0]        pos_x,
	input  logic signed [COORD_BITS-1:0]        pos_y,
	input  logic signed [COORD_BITS-1:0]        pos_z,
	input  logic                                cfg_we,
	input  logic        [lcsi_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic        [lcsi_pkg::CFG_W-1:0]   cfg_data,
	output logic                                done,
	output logic        [lcsi_pkg::IDX_W-1:0]   site_index,
	output logic                                valid_res
);
	import lcsi_pkg::*;

	localparam int W          = COORD_BITS;
	localparam int NB         = $clog2(MAX_CELLS + 1);
	localparam int MOD_STAGES = (COORD_BITS + MOD_STEP - 1) / MOD_STEP;
	localparam int MOD_LAT    = MOD_STAGES + 2;

	// Effective extent: zero acts as one, large values saturate.
	function automatic logic [NB-1:0] ext_f(input logic [CFG_W-1:0] r);
		logic [31:0] rv;
		rv = 32'(r);
		if (rv == 32'd0) begin
			ext_f = NB'(1);
		end else if (rv > 32'(MAX_CELLS)) begin
			ext_f = NB'(MAX_CELLS);
		end else begin
			ext_f = NB'(r);
		end
	endfunction

	// Extent registers.
	logic [CFG_W-1:0] cells_x_q, cells_y_q, cells_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_x_q <= CELLS_RESET;
			cells_y_q <= CELLS_RESET;
			cells_z_q <= CELLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CELLS_X: cells_x_q <= cfg_data;
				REG_CELLS_Y: cells_y_q <= cfg_data;
				REG_CELLS_Z: cells_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [NB-1:0] n0, n1, n2;
	assign n0 = ext_f(cells_x_q);
	assign n1 = ext_f(cells_y_q);
	assign n2 = ext_f(cells_z_q);

	assign busy = 1'b0;

	// Stage 1: sublattice match, cell coordinates along y and x, and x+y-z.
	logic [NUM_SUB-1:0] hit;
	logic [1:0]         sl_w;
	logic               match_w;

	always_comb begin
		for (int k = 0; k < NUM_SUB; k++) begin
			hit[k] = (pos_x[2:0] == SUB_OFF[k][0]) && (pos_y[2:0] == SUB_OFF[k][1]) &&
				(pos_z[2:0] == SUB_OFF[k][2]);
		end
		match_w = |hit;
		sl_w = 2'd0;
		for (int k = NUM_SUB - 1; k >= 0; k--) begin
			if (hit[k]) begin
				sl_w = 2'(k);
			end
		end
	end

	logic                valid_s1, match_s1;
	logic [1:0]          sl_s1;
	logic signed [W-4:0] qy_s1, qx_s1;
	logic signed [W+1:0] sum_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		match_s1 <= match_w;
		sl_s1    <= sl_w;
		qy_s1    <= pos_y[W-1:3];
		qx_s1    <= pos_x[W-1:3];
		sum_s1   <= {{2{pos_x[W-1]}}, pos_x} + {{2{pos_y[W-1]}}, pos_y} -
			{{2{pos_z[W-1]}}, pos_z};
	end

	// Stage 2: cell offsets relative to the diagonal coordinate.
	logic signed [W-3:0] q2_w;
	logic signed [W-1:0] q2_ext, qy_ext, qx_ext;
	assign q2_w   = sum_s1[W+1:4];
	assign q2_ext = {{2{q2_w[W-3]}}, q2_w};
	assign qy_ext = {{3{qy_s1[W-4]}}, qy_s1};
	assign qx_ext = {{3{qx_s1[W-4]}}, qx_s1};

	side_t               side_s2;
	logic signed [W-1:0] a0_s2, a1_s2, a2_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2 <= '0;
		end else begin
			side_s2 <= '{valid: valid_s1, match: match_s1, sl: sl_s1};
		end
	end

	always_ff @(posedge clk) begin
		a0_s2 <= qy_ext - q2_ext;
		a1_s2 <= qx_ext - q2_ext;
		a2_s2 <= q2_ext;
	end

	// Remainder lanes, one per cell axis.
	logic [NB-1:0] c0, c1, c2;

	lcsi_wrap_mod #(.DW(W), .NB(NB), .STEP(MOD_STEP), .STAGES(MOD_STAGES)) u_mod0 (
		.clk(clk), .value(a0_s2), .n(n0), .rem(c0)
	);
	lcsi_wrap_mod #(.DW(W), .NB(NB), .STEP(MOD_STEP), .STAGES(MOD_STAGES)) u_mod1 (
		.clk(clk), .value(a1_s2), .n(n1), .rem(c1)
	);
	lcsi_wrap_mod #(.DW(W), .NB(NB), .STEP(MOD_STEP), .STAGES(MOD_STAGES)) u_mod2 (
		.clk(clk), .value(a2_s2), .n(n2), .rem(c2)
	);

	// Side information delayed to line up with the remainder lanes.
	side_t side_line [0:MOD_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MOD_LAT; i++) begin
				side_line[i] <= '0;
			end
		end else begin
			side_line[0] <= side_s2;
			for (int i = 1; i < MOD_LAT; i++) begin
				side_line[i] <= side_line[i-1];
			end
		end
	end

	// Stage 3: c0 times the y extent.
	side_t            side_s3;
	logic [IDX_W-1:0] prod_s3;
	logic [NB-1:0]    c1_s3, c2_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else begin
			side_s3 <= side_line[MOD_LAT-1];
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= IDX_W'(c0) * IDX_W'(n1);
		c1_s3   <= c1;
		c2_s3   <= c2;
	end

	// Stage 4: add c1, then times the z extent.
	side_t            side_s4;
	logic [IDX_W-1:0] acc_s4;
	logic [NB-1:0]    c2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s4 <= '0;
		end else begin
			side_s4 <= side_s3;
		end
	end

	always_ff @(posedge clk) begin
		acc_s4 <= (prod_s3 + IDX_W'(c1_s3)) * IDX_W'(n2);
		c2_s4  <= c2_s3;
	end

	// Output stage: add c2, append the sublattice, zero on a miss.
	logic [IDX_W-1:0] cell_w;
	logic [IDX_W-1:0] site_index_q;
	logic             valid_res_q, done_q;

	assign cell_w = acc_s4 + IDX_W'(c2_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= side_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		valid_res_q  <= side_s4.match;
		site_index_q <= side_s4.match ? {cell_w[IDX_W-3:0], side_s4.sl} : '0;
	end

	assign done       = done_q;
	assign site_index = site_index_q;
	assign valid_res  = valid_res_q;

endmodule

[test/tb_top.sv]
// Self-checking testbench for the lattice coordinate to site index unit.
module tb_top;
	import lcsi_pkg::*;

	localparam int COORD_W    = 16;
	localparam int LATENCY    = 11;
	localparam int LIMIT      = 200000;
	localparam int NUM_PHASES = 10;
	localparam int PHASE_LEN  = 75;

	// The one register index that maps to no extent register.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct {
		logic [IDX_W-1:0] idx;
		logic             valid;
	} site_t;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		bit                 typed;
		site_t              want;
	} coord_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [COORD_W-1:0]   pos_x;
	logic [COORD_W-1:0]   pos_y;
	logic [COORD_W-1:0]   pos_z;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;
	logic                 done;
	logic [IDX_W-1:0]     site_index;
	logic                 valid_res;

	// Local copy of the extent registers.
	logic [CFG_W-1:0] ext_x;
	logic [CFG_W-1:0] ext_y;
	logic [CFG_W-1:0] ext_z;

	site_t      site_q[$];
	coord_row_t coord_tab[$];
	site_t      head_site;
	int         errors;
	int         cycles;

	lattice_coord_to_site_index_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.site_index (site_index),
		.valid_res  (valid_res)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Effective extent: zero acts as one, anything above the maximum saturates.
	function automatic longint eff_extent(input logic [CFG_W-1:0] v);
		if (v == 0) begin
			return 1;
		end
		if (v > 64) begin
			return 64;
		end
		return v;
	endfunction

	// Wrap a value into the range 0 to n-1.
	function automatic longint wrap_cell(input longint a, input longint n);
		longint r;
		r = a % n;
		if (r < 0) begin
			r = r + n;
		end
		return r;
	endfunction

	// Predict the site index for one position under the current extents.
	function automatic site_t predict_site(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic signed [COORD_W-1:0] sz;
		longint px, py, pz, q0, q1, q2, n0, n1, n2, c0, c1, c2, idx;
		int     sl;
		site_t  r;
		sx = x;
		sy = y;
		sz = z;
		px = sx;
		py = sy;
		pz = sz;
		// The sublattice is decided by the low three bits of each axis.
		case ({x[2:0], y[2:0], z[2:0]})
			{3'd0, 3'd0, 3'd0}: sl = 0;
			{3'd0, 3'd4, 3'd4}: sl = 1;
			{3'd4, 3'd0, 3'd4}: sl = 2;
			{3'd4, 3'd4, 3'd0}: sl = 3;
			default:            sl = NUM_SUB;
		endcase
		if (sl == NUM_SUB) begin
			r.idx   = '0;
			r.valid = 1'b0;
			return r;
		end
		n0  = eff_extent(ext_x);
		n1  = eff_extent(ext_y);
		n2  = eff_extent(ext_z);
		// Floor division by a power of two is an arithmetic shift.
		q0  = py >>> 3;
		q1  = px >>> 3;
		q2  = (px + py - pz) >>> 4;
		c0  = wrap_cell(q0 - q2, n0);
		c1  = wrap_cell(q1 - q2, n1);
		c2  = wrap_cell(q2, n2);
		idx = ((c0 * n1 + c1) * n2 + c2) * 4 + sl;
		r.idx   = idx[IDX_W-1:0];
		r.valid = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("ERROR at cycle %0d: %s", cycles, what);
		errors++;
	endtask

	task automatic add_row(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input bit typed, input int idx, input bit valid);
		coord_row_t row;
		row.x          = x;
		row.y          = y;
		row.z          = z;
		row.typed      = typed;
		row.want.idx   = IDX_W'(idx);
		row.want.valid = valid;
		coord_tab.push_back(row);
	endtask

	// Present one word and hold it until the unit takes it.
	task automatic send_word(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input site_t want);
		start <= 1'b1;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		@(posedge clk);
		while (busy) begin
			@(posedge clk);
		end
		site_q.push_back(want);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_CELLS_X: ext_x = val;
			REG_CELLS_Y: ext_y = val;
			REG_CELLS_Z: ext_z = val;
			default:     ;
		endcase
	endtask

	// Wait until every word has produced its result, then let the pipeline settle.
	task automatic drain_results();
		start <= 1'b0;
		while (site_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	// Mostly lattice sites with random cell content, the rest noise and near misses.
	task automatic random_coord(output logic [COORD_W-1:0] x, output logic [COORD_W-1:0] y,
			output logic [COORD_W-1:0] z);
		int         sl;
		int         kind;
		logic [3:0] pick;
		sl   = $urandom_range(3);
		kind = $urandom_range(99);
		x = COORD_W'($urandom);
		y = COORD_W'($urandom);
		z = COORD_W'($urandom);
		if (kind < 85) begin
			x[2:0] = (sl == 2 || sl == 3) ? 3'd4 : 3'd0;
			y[2:0] = (sl == 1 || sl == 3) ? 3'd4 : 3'd0;
			z[2:0] = (sl == 1 || sl == 2) ? 3'd4 : 3'd0;
			// A near miss: one low bit flipped off the sublattice.
			if (kind >= 70) begin
				case ($urandom_range(2))
					0: begin
						pick    = 4'($urandom_range(2));
						x[pick] = ~x[pick];
					end
					1: begin
						pick    = 4'($urandom_range(1));
						y[pick] = ~y[pick];
					end
					default: z[0] = ~z[0];
				endcase
			end
		end
	endtask

	// Result checker: every strobed result is matched against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (site_q.size() == 0) begin
				report_mismatch("result with no word pending");
			end else begin
				head_site = site_q.pop_front();
				if (site_index !== head_site.idx) begin
					report_mismatch($sformatf("site_index %0d, expected %0d",
						site_index, head_site.idx));
				end
				if (valid_res !== head_site.valid) begin
					report_mismatch($sformatf("valid_res %b, expected %b",
						valid_res, head_site.valid));
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		logic [COORD_W-1:0] rx, ry, rz;
		logic [CFG_W-1:0]   vx, vy, vz;
		int                 idle_pct;
		errors    = 0;
		cycles    = 0;
		arst_n    = 1'b0;
		start     = 1'b0;
		pos_x     = '0;
		pos_y     = '0;
		pos_z     = '0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		ext_x     = CELLS_RESET;
		ext_y     = CELLS_RESET;
		ext_z     = CELLS_RESET;

		// Directed words; the first rows carry results that follow directly from reset.
		add_row(16'd0, 16'd0, 16'd0, 1, 0, 1);
		add_row(16'd1, 16'd0, 16'd0, 1, 0, 0);
		add_row(16'd0, 16'd4, 16'd4, 1, 1, 1);
		add_row(16'd4, 16'd0, 16'd4, 1, 2, 1);
		add_row(16'd4, 16'd4, 16'd0, 1, 3, 1);
		add_row(16'h8000, 16'h8000, 16'h8000, 1, 0, 1);
		add_row(16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 0, 0);
		add_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 0);
		add_row(16'd0, 16'd0, 16'd4, 1, 0, 0);
		add_row(16'd8, 16'd0, 16'd0, 0, 0, 0);
		add_row(16'd0, 16'd8, 16'd0, 0, 0, 0);
		add_row(16'd0, 16'd0, 16'd8, 0, 0, 0);
		add_row(16'd0, 16'd0, -16'sd8, 0, 0, 0);
		add_row(-16'sd8, 16'd0, 16'd0, 0, 0, 0);
		add_row(-16'sd4, -16'sd4, 16'd0, 0, 0, 0);
		add_row(16'd32760, 16'd32760, 16'd32760, 0, 0, 0);
		add_row(16'h8000, 16'd32760, 16'd0, 0, 0, 0);
		add_row(16'd32764, -16'sd32764, 16'd0, 0, 0, 0);
		add_row(16'h8000, 16'd0, 16'h7FFF, 0, 0, 0);
		add_row(16'd16, 16'd16, -16'sd16, 0, 0, 0);
		add_row(16'd100, 16'd36, -16'sd20, 0, 0, 0);
		add_row(-16'sd1020, 16'd2044, -16'sd3068, 0, 0, 0);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (coord_tab[i]) begin
			send_word(coord_tab[i].x, coord_tab[i].y, coord_tab[i].z,
				coord_tab[i].typed ? coord_tab[i].want
					: predict_site(coord_tab[i].x, coord_tab[i].y, coord_tab[i].z));
		end
		drain_results();

		// Random phases, each under its own extents and idle pattern.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0:       begin vx = 7'd4;   vy = 7'd4;   vz = 7'd4;   end
				1:       begin vx = 7'd1;   vy = 7'd1;   vz = 7'd1;   end
				2:       begin vx = 7'd64;  vy = 7'd64;  vz = 7'd64;  end
				3:       begin vx = 7'd0;   vy = 7'd0;   vz = 7'd0;   end
				4:       begin vx = 7'd127; vy = 7'd127; vz = 7'd127; end
				5:       begin vx = 7'd65;  vy = 7'd2;   vz = 7'd37;  end
				6:       begin vx = 7'd3;   vy = 7'd64;  vz = 7'd1;   end
				default: begin
					vx = CFG_W'($urandom_range(127));
					vy = CFG_W'($urandom_range(127));
					vz = CFG_W'($urandom_range(127));
				end
			endcase
			write_reg(REG_CELLS_X, vx);
			write_reg(REG_CELLS_Y, vy);
			write_reg(REG_CELLS_Z, vz);
			// A write to the unused index must leave the extents alone.
			write_reg(REG_UNUSED, CFG_W'($urandom_range(127)));
			cfg_we <= 1'b0;
			@(posedge clk);

			case (p % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 59;
				default: idle_pct = 27;
			endcase
			for (int n = 0; n < PHASE_LEN; n++) begin
				if ($urandom_range(99) < idle_pct) begin
					start <= 1'b0;
					@(posedge clk);
					while ($urandom_range(99) < idle_pct) begin
						@(posedge clk);
					end
				end
				random_coord(rx, ry, rz);
				send_word(rx, ry, rz, predict_site(rx, ry, rz));
			end
			drain_results();
		end

		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
